// ----- rtl/stxd_pkg.sv -----
// ----------------------------------------------------------------------------
// stxd_pkg
// Shared constants and types for the framed packet deframer.
// ----------------------------------------------------------------------------
package stxd_pkg;

  // Payload buffer depth (largest packet length the block can hold)
  localparam int MAX_PAYLOAD_BYTES = 32;

  // Derived widths
  localparam int ADDR_W = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;
  localparam int LEN_W  = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam int POS_W  = $clog2(MAX_PAYLOAD_BYTES + 4);

  // Field widths fixed by the interface
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int IDX_W   = 5;
  localparam int MAXP_W  = 6;
  localparam int CADDR_W = 2;
  localparam int TDATA_W = 16;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [KIND_W-1:0] kind_t;

  // Result kinds
  localparam kind_t KIND_DATA   = 2'd0;
  localparam kind_t KIND_EMPTY  = 2'd1;
  localparam kind_t KIND_BADSUM = 2'd2;
  localparam kind_t KIND_ABORT  = 2'd3;

  // Register indexes
  localparam logic [CADDR_W-1:0] REG_START_MARKER = 2'd0;
  localparam logic [CADDR_W-1:0] REG_END_MARKER   = 2'd1;
  localparam logic [CADDR_W-1:0] REG_MAX_PAYLOAD  = 2'd2;

  // Register reset values
  localparam byte_t              START_MARKER_RST = 8'h02;
  localparam byte_t              END_MARKER_RST   = 8'h03;
  localparam logic [MAXP_W-1:0]  MAX_PAYLOAD_RST  = 6'd32;

endpackage

// ----- rtl/stxd_ram.sv -----
// ----------------------------------------------------------------------------
// stxd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module stxd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/stx_etx_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// stx_etx_packet_deframer
// Recovers start/length/payload/check/end framed packets from a byte stream.
// ----------------------------------------------------------------------------
// Received bytes are taken one at a time. Packets are start marker, length
// L, L payload bytes, an XOR check byte (XOR of start, length and payload)
// and the end marker. Payload bytes go into a small RAM as they arrive. When
// the end byte of a good packet arrives, the payload is read back as a run of
// L results with tlast on the final one: each byte is read from the RAM,
// loaded into the output register and transferred before the next read,
// and a stalling sink holds the readout back; no input is taken during that
// readout. An empty packet gives one empty-packet result, a bad check byte
// one checksum result, and a line error, an over-long length or a missing
// end byte one abort result. Bytes outside a packet are dropped. A result
// waiting in the output register holds off the next byte until its transfer;
// the byte is taken in the same cycle as that transfer.
// ----------------------------------------------------------------------------
module stx_etx_packet_deframer (
  input  logic                          clk,
  input  logic                          rst_n,
  // Received bytes
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] rx_byte
  input  logic                          in_tuser,   // [0] line_error
  // Results
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [stxd_pkg::TDATA_W-1:0]  out_tdata,  // [7:0] data, [12:8] index
  output logic [1:0]                    out_tuser,  // [1:0] kind
  output logic                          out_tlast,
  // Configuration writes
  input  logic                          cfg_we,
  input  logic [stxd_pkg::CADDR_W-1:0]  cfg_addr,
  input  logic [7:0]                    cfg_wdata
);

  import stxd_pkg::*;

  localparam logic [1:0] S_RUN  = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  // Configuration registers
  byte_t              start_r;
  byte_t              end_r;
  logic [MAXP_W-1:0]  maxp_r;

  // Framing state
  logic [1:0]         state_r, state_nxt;
  logic               in_packet_r, in_packet_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  byte_t              xor_r, xor_nxt;
  logic [LEN_W-1:0]   rd_idx_r, rd_idx_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  kind_t              out_kind_r;
  byte_t              out_data_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic               out_last_r;

  // Result load
  logic               res_load;
  kind_t              res_kind;
  byte_t              res_data;
  logic [IDX_W-1:0]   res_idx;
  logic               res_last;

  // RAM ports
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic               ram_re;
  byte_t              ram_rdata;

  logic               in_acc;
  byte_t              b;
  logic [POS_W-1:0]   len_pos;
  logic [POS_W-1:0]   ck_pos;
  logic [POS_W-1:0]   wr_off;
  logic               rd_last;

  assign in_tready  = (state_r == S_RUN) && (!out_valid_r || out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign b          = in_tdata;
  assign len_pos    = POS_W'(len_r);
  assign ck_pos     = len_pos + POS_W'(2);
  assign wr_off     = pos_r - POS_W'(2);
  assign ram_waddr  = wr_off[ADDR_W-1:0];
  assign rd_last    = (rd_idx_r + LEN_W'(1)) == len_r;

  // Payload buffer
  stxd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD_BYTES)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (b),
    .re    (ram_re),
    .raddr (rd_idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_MARKER_RST;
      end_r   <= END_MARKER_RST;
      maxp_r  <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_START_MARKER: start_r <= cfg_wdata;
        REG_END_MARKER:   end_r   <= cfg_wdata;
        REG_MAX_PAYLOAD:  maxp_r  <= cfg_wdata[MAXP_W-1:0];
        default:          ;
      endcase
    end
  end

  // Framing and readout sequencer
  always_comb begin
    state_nxt     = state_r;
    in_packet_nxt = in_packet_r;
    pos_nxt       = pos_r;
    len_nxt       = len_r;
    xor_nxt       = xor_r;
    rd_idx_nxt    = rd_idx_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    res_load      = 1'b0;
    res_kind      = KIND_ABORT;
    res_data      = '0;
    res_idx       = '0;
    res_last      = 1'b1;

    case (state_r)
      S_RUN: begin
        if (in_acc) begin
          if (!in_packet_r) begin
            // Hunt for an error-free start marker
            if (!in_tuser && (b == start_r)) begin
              in_packet_nxt = 1'b1;
              pos_nxt       = POS_W'(1);
              xor_nxt       = b;
            end
          end else if (in_tuser) begin
            // Line error: abort and drop the byte
            res_load      = 1'b1;
            in_packet_nxt = 1'b0;
            pos_nxt       = '0;
            xor_nxt       = '0;
          end else if (pos_r == POS_W'(1)) begin
            // Length byte
            if ((b > {2'b00, maxp_r}) || (b > BYTE_W'(MAX_PAYLOAD_BYTES))) begin
              res_load      = 1'b1;
              in_packet_nxt = 1'b0;
              pos_nxt       = '0;
              xor_nxt       = '0;
            end else begin
              len_nxt = LEN_W'(b);
              xor_nxt = xor_r ^ b;
              pos_nxt = POS_W'(2);
            end
          end else if (pos_r < ck_pos) begin
            // Payload byte: buffer it
            ram_we  = 1'b1;
            xor_nxt = xor_r ^ b;
            pos_nxt = pos_r + POS_W'(1);
          end else if (pos_r == ck_pos) begin
            // Check byte folds in: zero means a match
            xor_nxt = xor_r ^ b;
            pos_nxt = pos_r + POS_W'(1);
          end else begin
            // End byte position: back to hunting in every case
            in_packet_nxt = 1'b0;
            pos_nxt       = '0;
            xor_nxt       = '0;
            if (b != end_r) begin
              res_load = 1'b1;
            end else if (xor_r != '0) begin
              res_load = 1'b1;
              res_kind = KIND_BADSUM;
            end else if (len_r == '0) begin
              res_load = 1'b1;
              res_kind = KIND_EMPTY;
            end else begin
              rd_idx_nxt = '0;
              state_nxt  = S_READ;
            end
          end
        end
      end

      S_READ: begin
        // Issue the read once the output register is free
        if (!out_valid_r) begin
          ram_re    = 1'b1;
          state_nxt = S_LOAD;
        end
      end

      S_LOAD: begin
        // Load the payload byte into the output register
        res_load   = 1'b1;
        res_kind   = KIND_DATA;
        res_data   = ram_rdata;
        res_idx    = IDX_W'(rd_idx_r);
        res_last   = rd_last;
        rd_idx_nxt = rd_idx_r + LEN_W'(1);
        state_nxt  = rd_last ? S_RUN : S_READ;
      end

      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  // Hold a result until its transfer, then free the register
  assign out_valid_nxt = res_load ? 1'b1 : (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      in_packet_r <= 1'b0;
      pos_r       <= '0;
      len_r       <= '0;
      xor_r       <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_packet_r <= in_packet_nxt;
      pos_r       <= pos_nxt;
      len_r       <= len_nxt;
      xor_r       <= xor_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_kind_r <= res_kind;
      out_data_r <= res_data;
      out_idx_r  <= res_idx;
      out_last_r <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_idx_r, out_data_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // Readout only runs for a non-empty packet
  a_readout_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_RUN) |-> (len_r != '0))
    else $error("readout started for an empty packet");

  // Read index stays inside the packet during readout
  a_readout_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_RUN) |-> (rd_idx_r < len_r))
    else $error("readout index beyond packet length");

  // RAM data is loaded only after a read issued with a free output register
  a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) && !out_valid_r |=> (state_r == S_LOAD) && !out_valid_r)
    else $error("payload load without a matching read");

  // No input transfer in the load state of the readout
  a_no_input_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> !in_acc)
    else $error("input taken during payload readout");

endmodule

// ----- tb/sv/tb_stx_etx_packet_deframer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stx_etx_packet_deframer
// Self-checking bench for the framed packet deframer. A short table of hand
// picked bytes runs first, then random framed packets (some corrupted, some
// with line noise between them) under several marker and length settings.
// Every accepted byte runs through a local deframing model whose results are
// queued and compared field by field with the result stream.
// ----------------------------------------------------------------------------
module tb_stx_etx_packet_deframer;
  import stxd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 400;
  // Register index with nothing behind it
  localparam logic [CADDR_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [4:0]  idx;
    logic        last;
  } pkt_result_t;

  // How a table row is checked: by the model, no result, or one typed result
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} chk_t;

  typedef struct packed {
    logic [7:0]  rx;
    logic        err;
    chk_t        chk;
    kind_t       kind;
  } row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = 8'h00;   // [7:0] rx_byte
  logic                in_tuser = 1'b0;    // [0] line_error
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [TDATA_W-1:0]  out_tdata;          // [7:0] data, [12:8] index
  logic [1:0]          out_tuser;          // [1:0] kind
  logic                out_tlast;
  logic                cfg_we = 1'b0;
  logic [CADDR_W-1:0]  cfg_addr = '0;
  logic [7:0]          cfg_wdata = 8'h00;

  stx_etx_packet_deframer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Deframer model state and register copies
  logic              in_frame = 1'b0;
  int                pos = 0;
  int                len = 0;
  logic [7:0]        xsum = 8'h00;
  logic [7:0]        payload [MAX_PAYLOAD_BYTES];
  logic [7:0]        start_mk = START_MARKER_RST;
  logic [7:0]        end_mk = END_MARKER_RST;
  logic [MAXP_W-1:0] max_len = MAX_PAYLOAD_RST;

  pkt_result_t due_results[$];
  int          n_err = 0;
  int          cyc = 0;
  int          snd_pct = 0;
  int          rcv_pct = 0;
  int          stage = 0;
  logic        held = 1'b0;
  int          hold_left = 0;
  row_t        dir_rows [25];

  task automatic note_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    n_err++;
  endtask

  function automatic void go_hunt();
    in_frame = 1'b0;
    pos = 0;
    len = 0;
    xsum = 8'h00;
  endfunction

  function automatic int close_frame(input kind_t k);
    go_hunt();
    due_results.push_back('{k, 8'h00, 5'd0, 1'b1});
    return 1;
  endfunction

  // Advance the model by one accepted byte; return how many results it queued
  function automatic int deframe_byte(input logic [7:0] b, input logic err);
    int n;
    n = 0;
    if (!in_frame) begin
      if (!err && b == start_mk) begin
        in_frame = 1'b1;
        pos = 1;
        len = 0;
        xsum = b;
      end
    end else if (err) begin
      n = close_frame(KIND_ABORT);
    end else if (pos == 1) begin
      if (b > max_len || b > MAX_PAYLOAD_BYTES) begin
        n = close_frame(KIND_ABORT);
      end else begin
        len = b;
        xsum ^= b;
        pos = 2;
      end
    end else if (pos < len + 2) begin
      payload[pos-2] = b;
      xsum ^= b;
      pos++;
    end else if (pos == len + 2) begin
      xsum ^= b;
      pos++;
    end else if (b != end_mk) begin
      n = close_frame(KIND_ABORT);
    end else if (xsum != 8'h00) begin
      n = close_frame(KIND_BADSUM);
    end else if (len == 0) begin
      n = close_frame(KIND_EMPTY);
    end else begin
      for (int i = 0; i < len; i++)
        due_results.push_back('{KIND_DATA, payload[i], 5'(i), (i == len - 1)});
      n = len;
      go_hunt();
    end
    return n;
  endfunction

  task automatic check_result();
    pkt_result_t e;
    if (due_results.size() == 0) begin
      note_mismatch($sformatf("unexpected result kind %0d data %02h", out_tuser,
                              out_tdata[7:0]));
      return;
    end
    e = due_results.pop_front();
    if (out_tuser !== e.kind)
      note_mismatch($sformatf("kind %0d, want %0d", out_tuser, e.kind));
    if (out_tdata[7:0] !== e.data)
      note_mismatch($sformatf("data %02h, want %02h", out_tdata[7:0], e.data));
    if (out_tdata[12:8] !== e.idx)
      note_mismatch($sformatf("index %0d, want %0d", out_tdata[12:8], e.idx));
    if (out_tlast !== e.last)
      note_mismatch($sformatf("last %0b, want %0b", out_tlast, e.last));
  endtask

  // Result side: check each transfer, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      check_result();
    if (stage == 2 && !held) begin
      held = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("tb_stx_etx_packet_deframer: errors");
      $finish;
    end
  end

  // Offer one byte, hold it until transferred, then run it through the model
  task automatic push_byte(input logic [7:0] b, input logic err, output int n_new);
    while ($urandom_range(99) < snd_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= err;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_new = deframe_byte(b, err);
  endtask

  task automatic write_reg(input logic [CADDR_W-1:0] a, input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (a)
      REG_START_MARKER: start_mk = v;
      REG_END_MARKER:   end_mk = v;
      REG_MAX_PAYLOAD:  max_len = v[MAXP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Drop valid and drain every queued result before touching registers
  task automatic settle();
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Line noise between packets; keep it off the start marker so frames stay aligned
  task automatic send_noise();
    logic [7:0] b;
    logic       err;
    int         n;
    repeat ($urandom_range(1, 3)) begin
      b = 8'($urandom);
      err = $urandom_range(1);
      if (!err && b == start_mk)
        b ^= 8'h01;
      push_byte(b, err, n);
    end
  endtask

  // One packet, mostly well formed, sometimes with a bad check byte, a wrong
  // end byte, a line error partway through or an over-long length
  task automatic send_frame(output int sent);
    logic [8:0] seq[$];
    logic [7:0] ck;
    logic [7:0] d;
    int         lim;
    int         plen;
    int         flaw;
    int         cut;
    int         n;
    lim = (max_len < MAX_PAYLOAD_BYTES) ? int'(max_len) : MAX_PAYLOAD_BYTES;
    plen = ($urandom_range(99) < 10) ? lim : $urandom_range(0, (lim < 6) ? lim : 6);
    flaw = $urandom_range(99);
    ck = start_mk ^ 8'(plen);
    seq.push_back({1'b0, start_mk});
    if (flaw >= 95) begin
      seq.push_back({1'b0, 8'($urandom_range(lim + 1, 255))});
    end else begin
      seq.push_back({1'b0, 8'(plen)});
      for (int i = 0; i < plen; i++) begin
        d = 8'($urandom);
        ck ^= d;
        seq.push_back({1'b0, d});
      end
      if (flaw >= 80 && flaw < 87)
        ck ^= 8'($urandom_range(1, 255));
      seq.push_back({1'b0, ck});
      if (flaw >= 87 && flaw < 91)
        seq.push_back({1'b0, end_mk ^ 8'($urandom_range(1, 255))});
      else
        seq.push_back({1'b0, end_mk});
      if (flaw >= 91) begin
        cut = $urandom_range(1, seq.size() - 1);
        seq[cut][8] = 1'b1;
        seq = seq[0:cut];
      end
    end
    foreach (seq[i])
      push_byte(seq[i][7:0], seq[i][8], n);
    sent = seq.size();
  endtask

  task automatic run_phase(input int target);
    int count;
    int k;
    count = 0;
    while (count < target) begin
      if ($urandom_range(99) < 15)
        send_noise();
      send_frame(k);
      count += k;
    end
    settle();
  endtask

  initial begin
    int n_new;
    row_t r;
    dir_rows = '{
      // hunting: stray byte, start marker with line error
      '{8'h55, 1'b0, CHK_NONE,  KIND_DATA},
      '{8'h02, 1'b1, CHK_NONE,  KIND_DATA},
      // empty packet
      '{8'h02, 1'b0, CHK_NONE,  KIND_DATA},
      '{8'h00, 1'b0, CHK_NONE,  KIND_DATA},
      '{8'h02, 1'b0, CHK_NONE,  KIND_DATA},
      '{8'h03, 1'b0, CHK_ONE,   KIND_EMPTY},
      // length one past the limit
      '{8'h02, 1'b0, CHK_NONE,  KIND_DATA},
      '{8'h21, 1'b0, CHK_ONE,   KIND_ABORT},
      // one byte of all ones
      '{8'h02, 1'b0, CHK_NONE,  KIND_DATA},
      '{8'h01, 1'b0, CHK_NONE,  KIND_DATA},
      '{8'hFF, 1'b0, CHK_NONE,  KIND_DATA},
      '{8'hFC, 1'b0, CHK_NONE,  KIND_DATA},
      '{8'h03, 1'b0, CHK_MODEL, KIND_DATA},
      // bad check byte
      '{8'h02, 1'b0, CHK_NONE,  KIND_DATA},
      '{8'h00, 1'b0, CHK_NONE,  KIND_DATA},
      '{8'h00, 1'b0, CHK_NONE,  KIND_DATA},
      '{8'h03, 1'b0, CHK_ONE,   KIND_BADSUM},
      // start marker as payload, then a line error
      '{8'h02, 1'b0, CHK_NONE,  KIND_DATA},
      '{8'h01, 1'b0, CHK_NONE,  KIND_DATA},
      '{8'h02, 1'b0, CHK_NONE,  KIND_DATA},
      '{8'hA5, 1'b1, CHK_ONE,   KIND_ABORT},
      // start marker where the end byte belongs
      '{8'h02, 1'b0, CHK_NONE,  KIND_DATA},
      '{8'h00, 1'b0, CHK_NONE,  KIND_DATA},
      '{8'h02, 1'b0, CHK_NONE,  KIND_DATA},
      '{8'h02, 1'b0, CHK_ONE,   KIND_ABORT}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Slow receiver, busy sender, reset register values
    snd_pct = 36;
    rcv_pct = 75;
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      push_byte(r.rx, r.err, n_new);
      if (r.chk != CHK_MODEL) begin
        repeat (n_new) due_results.delete(due_results.size() - 1);
        if (r.chk == CHK_ONE)
          due_results.push_back('{r.kind, 8'h00, 5'd0, 1'b1});
      end
    end
    settle();
    run_phase(50);

    write_reg(REG_START_MARKER, 8'h00);
    write_reg(REG_END_MARKER, 8'hFF);
    write_reg(REG_MAX_PAYLOAD, 8'h00);
    run_phase(50);

    // Slow sender, mostly ready receiver, one long receiver hold-off
    snd_pct = 75;
    rcv_pct = 36;
    write_reg(REG_START_MARKER, 8'hFF);
    write_reg(REG_END_MARKER, 8'h00);
    write_reg(REG_MAX_PAYLOAD, 8'hE0);
    write_reg(REG_SPARE, 8'h5A);
    stage = 2;
    run_phase(50);

    write_reg(REG_START_MARKER, 8'($urandom));
    write_reg(REG_END_MARKER, 8'($urandom));
    write_reg(REG_MAX_PAYLOAD, 8'h01);
    run_phase(50);

    // No idling on either side
    snd_pct = 0;
    rcv_pct = 0;
    write_reg(REG_START_MARKER, 8'h7E);
    write_reg(REG_END_MARKER, 8'h7E);
    write_reg(REG_MAX_PAYLOAD, 8'h3F);
    run_phase(50);

    write_reg(REG_START_MARKER, 8'($urandom));
    write_reg(REG_END_MARKER, 8'($urandom));
    write_reg(REG_MAX_PAYLOAD, 8'($urandom_range(0, 63)));
    run_phase(50);

    if (n_err == 0)
      $display("tb_stx_etx_packet_deframer: clean");
    else
      $display("tb_stx_etx_packet_deframer: errors");
    $finish;
  end

endmodule
